>>> hdl/ist_pkg.sv
// Package for the interval set tracker: sizes, codes and shared types.
// No dependencies.
`default_nettype none
package ist_pkg;
    localparam int MAX_INTERVALS = 64;
    localparam int COORD_BITS    = 32;
    localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
    localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);
    localparam int ENTRY_BITS    = 2 * COORD_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [31:0] left;
        logic [31:0] right;
    } req_t;

    typedef struct packed {
        logic       covered;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic    we;
        idx_t    waddr;
        logic [ENTRY_BITS-1:0] wdata;
        idx_t    raddr;
    } mem_ctl_t;
endpackage
`default_nettype wire

>>> hdl/ist_if.sv
// Valid/ready channel interface carrying one transaction payload.
// Depends on ist_pkg, which gives the payload types.
`default_nettype none
interface ist_req_if;
    logic          valid;
    logic          ready;
    ist_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ist_rsp_if;
    logic          valid;
    logic          ready;
    ist_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/interval_set_tracker_top.sv
// Top level of the interval set tracker: sequencer plus table RAM.
// Depends on ist_pkg, ist_if, ist_ram and ist_ctrl.
//
// Keeps up to 64 disjoint sorted intervals in one RAM (start and end per word,
// registered read). A transaction is accepted only while the sequencer is idle
// and no result is waiting. The scan reads one entry at a time and checks it:
// the entries before the affected span, then the span and the first entry past it.
// The tail of the table then moves one entry per cycle and up to two new
// entries are written, one per cycle; empty-range and unused-op transactions
// skip the scan and the table. The result stays in an output register until
// taken, and the next transaction is accepted only after that.
`default_nettype none
module interval_set_tracker_top (
    input  wire logic clk,
    input  wire logic rst_n,
    ist_req_if.sink   req,
    ist_rsp_if.source rsp
);
    ist_pkg::mem_ctl_t               mem;
    logic [ist_pkg::ENTRY_BITS-1:0]  rdata;

    ist_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .mem   (mem),
        .rdata (rdata)
    );

    ist_ram #(
        .WIDTH (ist_pkg::ENTRY_BITS),
        .DEPTH (ist_pkg::MAX_INTERVALS)
    ) u_table (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );
endmodule
`default_nettype wire

>>> hdl/ist_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hdl/ist_ctrl.sv
// Sequencer: scans the interval table, then shifts and writes it.
// Depends on ist_pkg and ist_if; drives the table RAM through a mem_ctl_t bundle.
`default_nettype none
module ist_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ist_req_if.sink                             req,
    ist_rsp_if.source                           rsp,
    output ist_pkg::mem_ctl_t                   mem,
    input  wire logic [ist_pkg::ENTRY_BITS-1:0] rdata
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN_I, S_SCAN_J, S_DECIDE, S_MOVE, S_WRITE, S_RESP
    } state_t;

    state_t               state_reg;
    ist_pkg::cnt_t        count_reg;
    ist_pkg::cnt_t        ptr_reg;     // next tail entry to read
    ist_pkg::cnt_t        mv_reg;      // destination of the entry arriving this cycle
    ist_pkg::cnt_t        rem_reg;     // tail entries still to read
    ist_pkg::cnt_t        i_reg, j_reg, k_reg;
    logic                 rd_v_reg;
    logic                 up_reg;
    ist_pkg::op_t         op_reg;
    ist_pkg::coord_t      l_reg, r_reg;
    ist_pkg::coord_t      s0_reg, e0_reg, s1_reg, e1_reg;
    logic                 first_reg;
    ist_pkg::rsp_t        out_reg;
    logic                 ov_reg;
    logic                 wsel_reg;

    ist_pkg::coord_t      rs, re;
    ist_pkg::cnt_t        span;
    ist_pkg::cnt_t        dec_k;
    ist_pkg::cnt_t        dec_count;
    ist_pkg::cnt_t        newcount;
    ist_pkg::cnt_t        rd_addr;
    logic                 head_cut;
    logic                 tail_cut;

    assign rs = rdata[ist_pkg::ENTRY_BITS-1:ist_pkg::COORD_BITS];
    assign re = rdata[ist_pkg::COORD_BITS-1:0];
    assign span = ist_pkg::cnt_t'(j_reg - i_reg);
    assign head_cut = (s1_reg < l_reg);
    assign tail_cut = (e1_reg > r_reg);
    assign dec_k = (op_reg == ist_pkg::OP_ADD) ? ist_pkg::cnt_t'(1)
                 : ist_pkg::cnt_t'(head_cut) + ist_pkg::cnt_t'(tail_cut);
    assign dec_count = ist_pkg::cnt_t'(count_reg - span + dec_k);
    assign newcount = ist_pkg::cnt_t'(count_reg - span + k_reg);

    assign req.ready       = (state_reg == S_IDLE) && !ov_reg;
    assign rsp.valid       = ov_reg;
    assign rsp.payload     = out_reg;

    always_comb
    begin
        unique case (state_reg)
            S_SCAN_I: rd_addr = i_reg;
            S_SCAN_J: rd_addr = j_reg;
            default:  rd_addr = ptr_reg;
        endcase
        mem.raddr = rd_addr[ist_pkg::IDX_BITS-1:0];
        mem.we = 1'b0;
        mem.waddr = '0;
        mem.wdata = {s0_reg, e0_reg};
        unique case (state_reg)
            S_MOVE:
            begin
                mem.we = rd_v_reg;
                mem.waddr = ist_pkg::idx_t'(mv_reg);
                mem.wdata = rdata;
            end
            S_WRITE:
            begin
                mem.we = (ist_pkg::cnt_t'(wsel_reg) < k_reg);
                mem.waddr = ist_pkg::idx_t'(i_reg + ist_pkg::cnt_t'(wsel_reg));
                mem.wdata = wsel_reg ? {s1_reg, e1_reg} : {s0_reg, e0_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            rd_v_reg  <= 1'b0;
            ptr_reg   <= '0;
            mv_reg    <= '0;
            rem_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            up_reg    <= 1'b0;
            op_reg    <= ist_pkg::OP_NONE;
            l_reg     <= '0;
            r_reg     <= '0;
            s0_reg    <= '0;
            e0_reg    <= '0;
            s1_reg    <= '0;
            e1_reg    <= '0;
            first_reg <= 1'b0;
            out_reg   <= '0;
            wsel_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_RESP)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && !ov_reg)
                    begin
                        op_reg <= ist_pkg::op_t'(req.payload.operation);
                        l_reg  <= req.payload.left;
                        r_reg  <= req.payload.right;
                        out_reg.covered <= 1'b0;
                        i_reg   <= '0;
                        rd_v_reg <= 1'b0;
                        if (req.payload.operation == ist_pkg::OP_NONE)
                        begin
                            out_reg.status <= ist_pkg::ST_DONE;
                            state_reg <= S_RESP;
                        end
                        else if (req.payload.left >= req.payload.right)
                        begin
                            out_reg.status <= ist_pkg::ST_EMPTY;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            out_reg.status <= ist_pkg::ST_DONE;
                            state_reg <= S_SCAN_I;
                        end
                    end
                end
                S_SCAN_I:
                begin
                    // read of entry i_reg issued when !rd_v_reg, data checked next cycle
                    if (!rd_v_reg)
                    begin
                        if (i_reg >= count_reg)
                        begin
                            j_reg <= i_reg;
                            state_reg <= (op_reg == ist_pkg::OP_QUERY) ? S_RESP : S_DECIDE;
                        end
                        else
                        begin
                            rd_v_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        rd_v_reg <= 1'b0;
                        if ((op_reg == ist_pkg::OP_ADD) ? (re < l_reg) : (re <= l_reg))
                        begin
                            i_reg <= i_reg + ist_pkg::cnt_t'(1);
                        end
                        else if (op_reg == ist_pkg::OP_QUERY)
                        begin
                            out_reg.covered <= (rs <= l_reg) && (re >= r_reg);
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            j_reg <= i_reg;
                            first_reg <= 1'b1;
                            state_reg <= S_SCAN_J;
                        end
                    end
                end
                S_SCAN_J:
                begin
                    if (!rd_v_reg)
                    begin
                        if (j_reg >= count_reg)
                        begin
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            rd_v_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        rd_v_reg <= 1'b0;
                        if ((op_reg == ist_pkg::OP_ADD) ? (rs <= r_reg) : (rs < r_reg))
                        begin
                            if (first_reg)
                            begin
                                s1_reg <= rs;
                            end
                            first_reg <= 1'b0;
                            e1_reg <= re;
                            j_reg <= j_reg + ist_pkg::cnt_t'(1);
                        end
                        else
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    wsel_reg <= 1'b0;
                    k_reg <= dec_k;
                    rd_v_reg <= 1'b0;
                    if (op_reg == ist_pkg::OP_ADD)
                    begin
                        s0_reg <= (span != '0 && head_cut) ? s1_reg : l_reg;
                        e0_reg <= (span != '0 && tail_cut) ? e1_reg : r_reg;
                    end
                    else if (head_cut)
                    begin
                        // pieces: head [s,l) and maybe tail [r,e)
                        s0_reg <= s1_reg;
                        e0_reg <= l_reg;
                        s1_reg <= r_reg;
                    end
                    else
                    begin
                        s0_reg <= r_reg;
                        e0_reg <= e1_reg;
                    end
                    if (op_reg != ist_pkg::OP_ADD && span == '0)
                    begin
                        state_reg <= S_RESP;
                    end
                    else if (dec_count > ist_pkg::cnt_t'(ist_pkg::MAX_INTERVALS))
                    begin
                        out_reg.status <= ist_pkg::ST_FULL;
                        state_reg <= S_RESP;
                    end
                    else if (dec_k == span || j_reg >= count_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else if (dec_k < span)
                    begin
                        // tail moves down, ascending
                        up_reg  <= 1'b0;
                        ptr_reg <= j_reg;
                        mv_reg  <= ist_pkg::cnt_t'(i_reg + dec_k);
                        rem_reg <= ist_pkg::cnt_t'(count_reg - j_reg);
                        state_reg <= S_MOVE;
                    end
                    else
                    begin
                        // tail moves up by one, descending
                        up_reg  <= 1'b1;
                        ptr_reg <= count_reg - ist_pkg::cnt_t'(1);
                        mv_reg  <= count_reg;
                        rem_reg <= ist_pkg::cnt_t'(count_reg - j_reg);
                        state_reg <= S_MOVE;
                    end
                end
                S_MOVE:
                begin
                    if (rd_v_reg)
                    begin
                        mv_reg <= up_reg ? mv_reg - ist_pkg::cnt_t'(1)
                                         : mv_reg + ist_pkg::cnt_t'(1);
                    end
                    if (rem_reg == '0)
                    begin
                        rd_v_reg <= 1'b0;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        rd_v_reg <= 1'b1;
                        ptr_reg <= up_reg ? ptr_reg - ist_pkg::cnt_t'(1)
                                          : ptr_reg + ist_pkg::cnt_t'(1);
                        rem_reg <= rem_reg - ist_pkg::cnt_t'(1);
                    end
                end
                S_WRITE:
                begin
                    if (ist_pkg::cnt_t'(wsel_reg) + ist_pkg::cnt_t'(1) >= k_reg)
                    begin
                        count_reg <= newcount;
                        state_reg <= S_RESP;
                    end
                    wsel_reg <= 1'b1;
                end
                S_RESP:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ist_pkg::cnt_t'(ist_pkg::MAX_INTERVALS))
        else $error("interval count beyond capacity");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem.we)
        else $error("table written while idle");
    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_reg.status != ist_pkg::ST_DONE) |-> $stable(count_reg))
        else $error("count changed on dropped transaction");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)))
        else $error("response changed while waiting");
endmodule
`default_nettype wire

>>> tb/sv/ist_tb_if.sv
// Shared testbench constants: idle percentages for the stimulus phases.
// No dependencies.
`timescale 1ns / 100ps
package ist_tb_util_pkg;
    localparam int SEND_GAP_A = 14;
    localparam int RECV_GAP_A = 56;
endpackage

>>> tb/sv/interval_set_tracker_top_test.sv
// Testbench for interval_set_tracker_top: drives add/remove/query transactions,
// predicts each result with a behavioral interval table, and checks every response.
// Depends on ist_pkg, ist_if, ist_tb_util_pkg and the RTL.
`timescale 1ns / 100ps
module interval_set_tracker_top_test;
    import ist_pkg::*;
    import ist_tb_util_pkg::*;

    logic clk;
    logic rst_n;
    ist_req_if req ();
    ist_rsp_if rsp ();

    interval_set_tracker_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    coord_t span_lo [MAX_INTERVALS];
    coord_t span_hi [MAX_INTERVALS];
    int     span_cnt;
    rsp_t   pending_rsp [$];
    int     mismatches;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     coord_range;
    bit     finished;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Replace entries [i,j) by k new ones; returns 0 if the table would overflow.
    function automatic bit table_splice(int i, int j, int k, coord_t ns [2], coord_t ne [2]);
        coord_t tmp_lo [MAX_INTERVALS];
        coord_t tmp_hi [MAX_INTERVALS];
        int     n;
        n = 0;
        if (span_cnt - (j - i) + k > MAX_INTERVALS)
            return 1'b0;
        for (int m = 0; m < i; m++)
        begin
            tmp_lo[n] = span_lo[m];
            tmp_hi[n] = span_hi[m];
            n++;
        end
        for (int m = 0; m < k; m++)
        begin
            tmp_lo[n] = ns[m];
            tmp_hi[n] = ne[m];
            n++;
        end
        for (int m = j; m < span_cnt; m++)
        begin
            tmp_lo[n] = span_lo[m];
            tmp_hi[n] = span_hi[m];
            n++;
        end
        span_lo  = tmp_lo;
        span_hi  = tmp_hi;
        span_cnt = n;
        return 1'b1;
    endfunction

    function automatic rsp_t predict_interval_op(req_t r);
        rsp_t   res;
        coord_t l;
        coord_t h;
        coord_t ns [2];
        coord_t ne [2];
        int     i;
        int     j;
        int     k;
        res = '0;
        l = r.left;
        h = r.right;
        i = 0;
        k = 0;
        ns[0] = '0;
        ne[0] = '0;
        ns[1] = '0;
        ne[1] = '0;
        if (op_t'(r.operation) == OP_NONE)
            return res;
        if (l >= h)
        begin
            res.status = ST_EMPTY;
            return res;
        end
        case (op_t'(r.operation))
            OP_ADD:
            begin
                while (i < span_cnt && span_hi[i] < l)
                    i++;
                j = i;
                while (j < span_cnt && span_lo[j] <= h)
                    j++;
                ns[0] = l;
                ne[0] = h;
                if (j > i)
                begin
                    if (span_lo[i] < l)
                        ns[0] = span_lo[i];
                    if (span_hi[j-1] > h)
                        ne[0] = span_hi[j-1];
                end
                if (!table_splice(i, j, 1, ns, ne))
                    res.status = ST_FULL;
            end
            OP_REMOVE:
            begin
                while (i < span_cnt && span_hi[i] <= l)
                    i++;
                j = i;
                while (j < span_cnt && span_lo[j] < h)
                    j++;
                if (j > i)
                begin
                    if (span_lo[i] < l)
                    begin
                        ns[k] = span_lo[i];
                        ne[k] = l;
                        k++;
                    end
                    if (span_hi[j-1] > h)
                    begin
                        ns[k] = h;
                        ne[k] = span_hi[j-1];
                        k++;
                    end
                    if (!table_splice(i, j, k, ns, ne))
                        res.status = ST_FULL;
                end
            end
            default:
            begin
                while (i < span_cnt && span_hi[i] <= l)
                    i++;
                res.covered = (i < span_cnt && span_lo[i] <= l && span_hi[i] >= h);
            end
        endcase
        return res;
    endfunction

    task automatic send_interval_op(op_t op, coord_t l, coord_t h);
        req_t r;
        r.operation = op;
        r.left      = l;
        r.right     = h;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.payload <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_rsp.push_back(predict_interval_op(r));
        @(negedge clk);
    endtask

    task automatic send_random_op();
        int     w;
        coord_t l;
        coord_t h;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            send_interval_op(op_t'($urandom_range(3)), $urandom, $urandom);
        end
        else
        begin
            l = $urandom_range(coord_range);
            w = $urandom_range(1, 12);
            h = coord_t'(l + w);
            if (pick < 6)
                h = l - $urandom_range(0, 3);
            if (pick < 45)
                send_interval_op(OP_ADD, l, h);
            else if (pick < 70)
                send_interval_op(OP_REMOVE, l, h);
            else
                send_interval_op(OP_QUERY, l, h);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (3 * MAX_INTERVALS + 20)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response covered=%0b status=%0d",
                             rsp.payload.covered, rsp.payload.status);
            end
            else
            begin
                rsp_t e;
                e = pending_rsp.pop_front();
                if (e.covered !== rsp.payload.covered || e.status !== rsp.payload.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp covered=%0b status=%0d, got covered=%0b status=%0d",
                                 e.covered, e.status, rsp.payload.covered, rsp.payload.status);
                end
            end
        end
    end

    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic test_directed();
        send_interval_op(OP_QUERY, 32'd0, 32'd1);
        send_interval_op(OP_ADD, 32'd10, 32'd20);
        send_interval_op(OP_ADD, 32'd20, 32'd30);
        send_interval_op(OP_QUERY, 32'd10, 32'd30);
        send_interval_op(OP_ADD, 32'd40, 32'd50);
        send_interval_op(OP_ADD, 32'd25, 32'd45);
        send_interval_op(OP_REMOVE, 32'd15, 32'd17);
        send_interval_op(OP_QUERY, 32'd14, 32'd18);
        send_interval_op(OP_REMOVE, 32'd100, 32'd200);
        send_interval_op(OP_ADD, 32'd5, 32'd5);
        send_interval_op(OP_REMOVE, 32'd9, 32'd3);
        send_interval_op(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
        send_interval_op(OP_NONE, 32'd1, 32'd9);
        send_interval_op(OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_interval_op(OP_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_interval_op(OP_ADD, 32'd0, 32'hFFFF_FFFF);
        send_interval_op(OP_QUERY, 32'h5555_5555, 32'hAAAA_AAAA);
        send_interval_op(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);
        send_interval_op(OP_QUERY, 32'd0, 32'd1);
    endtask

    // Fill the table to capacity, force add and split overflows, then merge and clear.
    task automatic test_table_full();
        for (int n = 0; n < MAX_INTERVALS; n++)
            send_interval_op(OP_ADD, coord_t'(n * 10), coord_t'(n * 10 + 5));
        send_interval_op(OP_ADD, 32'd1000, 32'd1002);
        send_interval_op(OP_REMOVE, 32'd21, 32'd23);
        send_interval_op(OP_ADD, 32'd4, 32'd10);
        send_interval_op(OP_REMOVE, 32'd0, 32'd1000);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
        begin
            coord_range = (n % 200 < 150) ? 400 : 2000;
            send_random_op();
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.payload = '0;
        rsp.ready   = 1'b0;
        span_cnt    = 0;
        mismatches  = 0;
        finished    = 1'b0;
        coord_range = 400;
        send_idle_pct = SEND_GAP_A;
        recv_idle_pct = RECV_GAP_A;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_table_full();
        test_random(400);
        send_idle_pct = RECV_GAP_A;
        recv_idle_pct = SEND_GAP_A;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        drain();
        finished = 1'b1;
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #40ms;
        if (!finished)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end
endmodule
